// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the frame decoder modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SBFD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SBFD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sbfd_pkg.sv =====
// ============================================================================
// sbfd_pkg
// Shared types and constants of the frame decoder and channel scaler.
// ============================================================================
package sbfd_pkg;

    // Frame layout
    localparam int FRAME_BYTES  = 25;
    localparam int FRAME_ADDR_W = $clog2(FRAME_BYTES);
    localparam int NUM_CH       = 18;
    localparam int NUM_ANALOG   = 16;
    localparam int CH_IDX_W     = 5;
    localparam int RAW_W        = 11;
    localparam int BYTE_W       = 8;
    localparam int ACC_W        = 18;
    localparam int BITS_W       = 5;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h0F;
    localparam logic [BYTE_W-1:0] FOOTER_BYTE = 8'h00;
    localparam logic [RAW_W-1:0]  RAW_FULL    = 11'h7FF;

    // Flag bits of the digital byte
    localparam int DIG0_BIT     = 0;
    localparam int DIG1_BIT     = 1;
    localparam int LOST_BIT     = 2;
    localparam int FAILSAFE_BIT = 3;

    // Arithmetic widths
    localparam int VAL_W      = 16;
    localparam int DIFF_W     = 17;
    localparam int PROD_W     = 28;
    localparam int DIVIDEND_W = 27;
    localparam int DIVISOR_W  = RAW_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam int SUM_W      = 19;
    localparam int QUO_W      = 18;

    // Q3.13 switch thresholds and levels
    localparam logic signed [VAL_W-1:0] Q_HALF    = 16'sd4096;
    localparam logic signed [VAL_W-1:0] Q_QUARTER = 16'sd2048;
    localparam logic signed [VAL_W-1:0] Q_3QUART  = 16'sd6144;
    localparam logic signed [VAL_W-1:0] Q_ZERO    = 16'sd0;
    localparam logic signed [VAL_W-1:0] Q_ONE     = 16'sd8192;
    localparam logic signed [VAL_W-1:0] Q_TWO     = 16'sd16384;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_MIN       = 3'd0,
        CFG_SRC_MAX       = 3'd1,
        CFG_DEST_LOW_S    = 3'd2,
        CFG_DEST_HIGH     = 3'd3,
        CFG_DEST_LOW_U    = 3'd4,
        CFG_THROTTLE_IDX  = 3'd5,
        CFG_ARM_IDX       = 3'd6,
        CFG_MODE_IDX      = 3'd7
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_ABS,
        S_EMIT,
        S_PREP,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_POST
    } state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
        logic rem_nz;
    } div_stat_t;

endpackage

// ===== hdl/sbus_frame_decoder_scaler.sv =====
// ============================================================================
// sbus_frame_decoder_scaler
// Serial RC frame decoder with per-channel linear scaling to Q3.13.
// ============================================================================
// Usage:
//   in_valid/in_ready takes one received byte per item; frame_start marks
//   byte 0. Bytes that do not complete a frame are taken back to back.
//   On the 25th byte a good frame is unpacked (a read and an absorb step
//   per buffer byte 1..23, an emit step per 11-bit channel); a bad frame
//   skips this. Then one result item per channel 0..OUT_CHANNELS-1 is
//   written to the output register (out_valid/out_ready) after a multiply
//   and a 27-step shared restoring divide; the divide is skipped if the
//   source range is empty. in_ready stays low until the last one is
//   written; the last result may still wait while the next bytes are
//   taken. A stalled receiver holds the result in the output register and
//   the sequencer waits before writing the next one.
//   Configuration writes take effect at once. Reset clears channels,
//   counters, flags and position; the frame buffer needs no clearing since
//   every frame is fully written before it is read.
// ============================================================================
`include "assert_macros.svh"

module sbus_frame_decoder_scaler #(
    parameter int OUT_CHANNELS = 6
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // byte input
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [sbfd_pkg::BYTE_W-1:0]           frame_byte,
    input  logic                                  frame_start,
    // result output
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [sbfd_pkg::CH_IDX_W-1:0]         channel_index,
    output logic [sbfd_pkg::RAW_W-1:0]            raw_value,
    output logic signed [sbfd_pkg::VAL_W-1:0]     channel_out,
    output logic                                  frame_valid,
    output logic                                  failsafe_flag,
    output logic [31:0]                           lost_count,
    output logic [31:0]                           error_count,
    output logic                                  last_result,
    // configuration
    input  logic                                  cfg_write,
    input  logic [sbfd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sbfd_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import sbfd_pkg::*;

    // Configuration registers
    logic [RAW_W-1:0]        src_min_reg;
    logic [RAW_W-1:0]        src_max_reg;
    logic signed [VAL_W-1:0] dest_low_s_reg;
    logic signed [VAL_W-1:0] dest_high_reg;
    logic signed [VAL_W-1:0] dest_low_u_reg;
    logic [CH_IDX_W-1:0]     throttle_idx_reg;
    logic [CH_IDX_W-1:0]     arm_idx_reg;
    logic [CH_IDX_W-1:0]     mode_idx_reg;

    // Sequencer and frame state
    state_t                  state_reg;
    state_t                  state_next;
    logic [FRAME_ADDR_W-1:0] pos_reg;
    logic [FRAME_ADDR_W-1:0] pos_eff;
    logic                    start_ok_reg;
    logic                    frame_ok_reg;
    logic [FRAME_ADDR_W-1:0] src_reg;
    logic [CH_IDX_W-1:0]     ch_reg;
    logic [BITS_W-1:0]       bits_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [CH_IDX_W-1:0]     k_reg;
    logic [RAW_W-1:0]        chan_store_reg [NUM_CH];
    logic                    failsafe_reg;
    logic [31:0]             lost_cnt_reg;
    logic [31:0]             error_cnt_reg;

    // Scaling datapath
    logic signed [VAL_W-1:0]  dlow_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [RAW_W-1:0]         dx_reg;
    logic                     empty_reg;
    logic                     is_arm_reg;
    logic                     is_mode_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_full;

    // Output register
    logic                     out_valid_reg;
    logic [CH_IDX_W-1:0]      out_idx_reg;
    logic [RAW_W-1:0]         out_raw_reg;
    logic signed [VAL_W-1:0]  out_val_reg;
    logic                     out_fv_reg;
    logic                     out_fs_reg;
    logic [31:0]              out_lost_reg;
    logic [31:0]              out_err_reg;
    logic                     out_last_reg;

    // Control strobes
    logic                     accept;
    logic                     frame_done;
    logic                     frame_good;
    logic                     ram_re;
    logic                     div_start;
    logic                     load_out;
    logic                     last_k;
    logic                     dig_step;

    // Frame buffer and divider
    logic [BYTE_W-1:0]        rd_data;
    logic [DIVIDEND_W-1:0]    div_dividend;
    logic [DIVIDEND_W-1:0]    div_quo;
    div_stat_t                div_stat;

    // Per-channel combinational values
    logic [RAW_W-1:0]         raw_k;
    logic                     k_arm;
    logic                     k_mode;
    logic                     k_uni;
    logic signed [VAL_W-1:0]  k_dlow;
    logic [RAW_W-1:0]         k_clip;
    logic [QUO_W-1:0]         uq;
    logic signed [SUM_W-1:0]  q_signed;
    logic signed [SUM_W-1:0]  v_sum;
    logic signed [VAL_W-1:0]  v_lin;
    logic signed [VAL_W-1:0]  v_arm;
    logic signed [VAL_W-1:0]  v_fin;
    logic [PROD_W-1:0]        prod_abs;

    // ------------------------------------------------------------------
    // Input side decode
    // ------------------------------------------------------------------
    assign accept     = in_valid && in_ready;
    assign pos_eff    = frame_start ? '0 : pos_reg;
    assign frame_done = (pos_eff == FRAME_ADDR_W'(FRAME_BYTES - 1));
    assign frame_good = start_ok_reg && (frame_byte == FOOTER_BYTE);
    assign last_k     = (k_reg == CH_IDX_W'(OUT_CHANNELS - 1));
    assign dig_step   = (ch_reg == CH_IDX_W'(NUM_ANALOG));

    sbfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (pos_eff),
        .wdata (frame_byte),
        .re    (ram_re),
        .raddr (src_reg),
        .rdata (rd_data)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && frame_done)
                begin
                    state_next = frame_good ? S_RD : S_PREP;
                end
            end
            S_RD:
            begin
                state_next = S_ABS;
            end
            S_ABS:
            begin
                if (dig_step)
                begin
                    state_next = S_PREP;
                end
                else if (bits_reg >= BITS_W'(RAW_W - BYTE_W))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_EMIT:
            begin
                state_next = S_RD;
            end
            S_PREP:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = empty_reg ? S_POST : S_DSTART;
            end
            S_DSTART:
            begin
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (load_out)
                begin
                    state_next = last_k ? S_IDLE : S_PREP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready  = 1'b0;
        ram_re    = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_RD:
            begin
                ram_re = 1'b1;
            end
            S_DSTART:
            begin
                div_start = 1'b1;
            end
            S_POST:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Channel role and clipping for channel k
    // ------------------------------------------------------------------
    always_comb
    begin
        raw_k  = chan_store_reg[k_reg];
        k_arm  = (arm_idx_reg == k_reg);
        k_mode = (mode_idx_reg == k_reg);
        k_uni  = k_arm || k_mode || (throttle_idx_reg == k_reg);
        k_dlow = k_uni ? dest_low_u_reg : dest_low_s_reg;
        if (raw_k < src_min_reg)
        begin
            k_clip = src_min_reg;
        end
        else if (raw_k > src_max_reg)
        begin
            k_clip = src_max_reg;
        end
        else
        begin
            k_clip = raw_k;
        end
    end

    assign prod_full    = PROD_W'(diff_reg) * PROD_W'($signed({1'b0, dx_reg}));
    assign prod_abs     = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign div_dividend = prod_abs[DIVIDEND_W-1:0];

    // ------------------------------------------------------------------
    // Floor of the quotient, offset and switch rules
    // ------------------------------------------------------------------
    always_comb
    begin
        uq = div_quo[QUO_W-1:0];
        if (prod_reg[PROD_W-1])
        begin
            q_signed = -$signed({1'b0, uq}) - SUM_W'(div_stat.rem_nz);
        end
        else
        begin
            q_signed = $signed({1'b0, uq});
        end
        v_sum = SUM_W'(dlow_reg) + q_signed;
        v_lin = empty_reg ? dlow_reg : v_sum[VAL_W-1:0];
        if (is_arm_reg)
        begin
            v_arm = (v_lin < Q_HALF) ? Q_ZERO : Q_ONE;
        end
        else
        begin
            v_arm = v_lin;
        end
        if (is_mode_reg)
        begin
            if (v_arm < Q_QUARTER)
            begin
                v_fin = Q_ZERO;
            end
            else if (v_arm < Q_3QUART)
            begin
                v_fin = Q_ONE;
            end
            else
            begin
                v_fin = Q_TWO;
            end
        end
        else
        begin
            v_fin = v_arm;
        end
    end

    sbfd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (src_max_reg - src_min_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_min_reg      <= 11'd200;
            src_max_reg      <= 11'd1800;
            dest_low_s_reg   <= -16'sd8192;
            dest_high_reg    <= 16'sd8183;
            dest_low_u_reg   <= 16'sd0;
            throttle_idx_reg <= 5'd0;
            arm_idx_reg      <= 5'd4;
            mode_idx_reg     <= 5'd5;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SRC_MIN:      src_min_reg      <= cfg_data[RAW_W-1:0];
                CFG_SRC_MAX:      src_max_reg      <= cfg_data[RAW_W-1:0];
                CFG_DEST_LOW_S:   dest_low_s_reg   <= $signed(cfg_data);
                CFG_DEST_HIGH:    dest_high_reg    <= $signed(cfg_data);
                CFG_DEST_LOW_U:   dest_low_u_reg   <= $signed(cfg_data);
                CFG_THROTTLE_IDX: throttle_idx_reg <= cfg_data[CH_IDX_W-1:0];
                CFG_ARM_IDX:      arm_idx_reg      <= cfg_data[CH_IDX_W-1:0];
                CFG_MODE_IDX:     mode_idx_reg     <= cfg_data[CH_IDX_W-1:0];
                default:          src_min_reg      <= src_min_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer, frame position, channel store and counters
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            start_ok_reg  <= 1'b0;
            frame_ok_reg  <= 1'b0;
            src_reg       <= '0;
            ch_reg        <= '0;
            bits_reg      <= '0;
            k_reg         <= '0;
            failsafe_reg  <= 1'b0;
            lost_cnt_reg  <= '0;
            error_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                chan_store_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // advance byte position, note the header byte
            if (accept)
            begin
                pos_reg <= frame_done ? '0 : pos_eff + 1'b1;
                if (pos_eff == '0)
                begin
                    start_ok_reg <= (frame_byte == HEADER_BYTE);
                end
                if (frame_done)
                begin
                    frame_ok_reg <= frame_good;
                    src_reg      <= FRAME_ADDR_W'(1);
                    ch_reg       <= '0;
                    bits_reg     <= '0;
                    k_reg        <= '0;
                    if (!frame_good)
                    begin
                        error_cnt_reg <= error_cnt_reg + 1'b1;
                    end
                end
            end

            // absorb a byte, or take the digital byte after the last channel
            if (state_reg == S_ABS)
            begin
                if (dig_step)
                begin
                    chan_store_reg[NUM_ANALOG]     <= rd_data[DIG0_BIT] ? RAW_FULL : '0;
                    chan_store_reg[NUM_ANALOG + 1] <= rd_data[DIG1_BIT] ? RAW_FULL : '0;
                    failsafe_reg <= rd_data[FAILSAFE_BIT];
                    if (rd_data[LOST_BIT])
                    begin
                        lost_cnt_reg <= lost_cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    src_reg  <= src_reg + 1'b1;
                    bits_reg <= bits_reg + BITS_W'(BYTE_W);
                end
            end

            // emit one analog channel
            if (state_reg == S_EMIT)
            begin
                chan_store_reg[ch_reg] <= acc_reg[RAW_W-1:0];
                ch_reg   <= ch_reg + 1'b1;
                bits_reg <= bits_reg - BITS_W'(RAW_W);
            end

            // step to next result channel
            if (load_out && !last_k)
            begin
                k_reg <= k_reg + 1'b1;
            end

            // hold result until taken
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        // bit accumulator
        if (accept && frame_done)
        begin
            acc_reg <= '0;
        end
        else if (state_reg == S_ABS && !dig_step)
        begin
            acc_reg <= acc_reg | (ACC_W'(rd_data) << bits_reg);
        end
        else if (state_reg == S_EMIT)
        begin
            acc_reg <= acc_reg >> RAW_W;
        end

        // operand setup for channel k
        if (state_reg == S_PREP)
        begin
            dlow_reg    <= k_dlow;
            diff_reg    <= DIFF_W'(dest_high_reg) - DIFF_W'(k_dlow);
            dx_reg      <= k_clip - src_min_reg;
            empty_reg   <= (src_max_reg <= src_min_reg);
            is_arm_reg  <= k_arm;
            is_mode_reg <= k_mode;
        end

        if (state_reg == S_MUL)
        begin
            prod_reg <= prod_full;
        end

        if (load_out)
        begin
            out_idx_reg  <= k_reg;
            out_raw_reg  <= raw_k;
            out_val_reg  <= v_fin;
            out_fv_reg   <= frame_ok_reg;
            out_fs_reg   <= failsafe_reg;
            out_lost_reg <= lost_cnt_reg;
            out_err_reg  <= error_cnt_reg;
            out_last_reg <= last_k;
        end
    end

    assign out_valid     = out_valid_reg;
    assign channel_index = out_idx_reg;
    assign raw_value     = out_raw_reg;
    assign channel_out   = out_val_reg;
    assign frame_valid   = out_fv_reg;
    assign failsafe_flag = out_fs_reg;
    assign lost_count    = out_lost_reg;
    assign error_count   = out_err_reg;
    assign last_result   = out_last_reg;

    `SBFD_ASSERT_IMP(a_ready_div_idle, in_ready, !div_stat.busy, "byte taken while dividing")
    `SBFD_ASSERT_IMP(a_last_index, out_valid && last_result, channel_index == CH_IDX_W'(OUT_CHANNELS - 1), "last flag on wrong channel")
    `SBFD_ASSERT_NXT(a_load_valid, load_out, out_valid, "loaded result not shown")

endmodule

// ===== hdl/sbfd_ram.sv =====
// ============================================================================
// sbfd_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module sbfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== hdl/sbfd_div.sv =====
// ============================================================================
// sbfd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
`include "assert_macros.svh"

module sbfd_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [sbfd_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [sbfd_pkg::DIVISOR_W-1:0]      divisor,
    output logic [sbfd_pkg::DIVIDEND_W-1:0]     quotient,
    output sbfd_pkg::div_stat_t                 stat
);
    import sbfd_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  q_bit;

    // One trial subtraction
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign q_bit     = (rem_shift >= {1'b0, dvs_reg});

    // Control: count iterations, pulse done at the end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIVIDEND_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift dividend out, quotient bits in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], q_bit};
            rem_reg <= q_bit ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        end
    end

    assign quotient    = quo_reg;
    assign stat.busy   = busy_reg;
    assign stat.done   = done_reg;
    assign stat.rem_nz = (rem_reg != '0);

    `SBFD_ASSERT_NXT(a_div_start_busy, start, busy_reg, "divider did not start")
    `SBFD_ASSERT_IMP(a_div_done_idle, done_reg, !busy_reg, "done while still busy")
    `SBFD_ASSERT_IMP(a_div_fell_done, $fell(busy_reg), done_reg, "busy dropped without done")

endmodule

// ===== dv/channel_result_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// channel_result_checker
// Watches the byte, result and configuration ports of the frame decoder,
// predicts the scaled channel items of every completed frame and compares
// each result item field by field against the oldest prediction.
// ============================================================================
module channel_result_checker #(
    parameter int OUT_CHANNELS = 6
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic [sbfd_pkg::BYTE_W-1:0]           frame_byte,
    input  logic                                  frame_start,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic [sbfd_pkg::CH_IDX_W-1:0]         channel_index,
    input  logic [sbfd_pkg::RAW_W-1:0]            raw_value,
    input  logic signed [sbfd_pkg::VAL_W-1:0]     channel_out,
    input  logic                                  frame_valid,
    input  logic                                  failsafe_flag,
    input  logic [31:0]                           lost_count,
    input  logic [31:0]                           error_count,
    input  logic                                  last_result,
    input  logic                                  cfg_write,
    input  logic [sbfd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sbfd_pkg::CFG_DATA_W-1:0]       cfg_data,
    output int                                    errors,
    output int                                    pending
);
    import sbfd_pkg::*;

    typedef struct packed {
        logic [CH_IDX_W-1:0]      idx;
        logic [RAW_W-1:0]         raw;
        logic signed [VAL_W-1:0]  value;
        logic                     good;
        logic                     failsafe;
        logic [31:0]              lost;
        logic [31:0]              bad;
        logic                     last;
    } chan_result_t;

    chan_result_t       expected_channels[$];

    // Mirror of the decoder state
    logic [CFG_DATA_W-1:0] cfg_reg [8];
    logic [BYTE_W-1:0]     frame_buf [FRAME_BYTES];
    int unsigned           byte_pos;
    logic [RAW_W-1:0]      chan_val [NUM_CH];
    logic                  failsafe_q;
    logic [31:0]           lost_q;
    logic [31:0]           bad_q;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    function automatic logic [CFG_DATA_W-1:0] cfg_mask(input cfg_idx_t idx);
        case (idx)
            CFG_SRC_MIN, CFG_SRC_MAX:                  return 16'h07FF;
            CFG_DEST_LOW_S, CFG_DEST_HIGH, CFG_DEST_LOW_U: return 16'hFFFF;
            default:                                   return 16'h001F;
        endcase
    endfunction

    // Clip to the source range, then map linearly with a floored quotient
    function automatic logic signed [VAL_W-1:0] scale_channel(
        input logic [RAW_W-1:0]       raw,
        input logic signed [VAL_W-1:0] dlow
    );
        longint lo, hi, x, dl, dh, num, den, quo;
        lo = longint'(cfg_reg[CFG_SRC_MIN][RAW_W-1:0]);
        hi = longint'(cfg_reg[CFG_SRC_MAX][RAW_W-1:0]);
        dl = longint'(dlow);
        dh = longint'($signed(cfg_reg[CFG_DEST_HIGH]));
        if (hi <= lo)
            return dlow;
        x = longint'(raw);
        if (x < lo)
            x = lo;
        if (x > hi)
            x = hi;
        num = (dh - dl) * (x - lo);
        den = hi - lo;
        quo = num / den;
        if ((num % den) != 0 && num < 0)
            quo = quo - 1;
        return VAL_W'(quo + dl);
    endfunction

    // Store one byte; on the 25th, check, unpack and queue the channel items
    task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic mark);
        logic [NUM_ANALOG*RAW_W-1:0] payload;
        logic                        good;
        logic                        is_arm;
        logic                        is_mode;
        logic                        is_uni;
        logic signed [VAL_W-1:0]     v;
        chan_result_t                r;
        if (mark)
            byte_pos = 0;
        if (byte_pos >= FRAME_BYTES)
            byte_pos = 0;
        frame_buf[byte_pos] = b;
        byte_pos++;
        if (byte_pos < FRAME_BYTES)
            return;
        byte_pos = 0;

        good = (frame_buf[0] == HEADER_BYTE) && (frame_buf[FRAME_BYTES-1] == FOOTER_BYTE);
        if (good)
        begin
            for (int i = 1; i <= 22; i++)
                payload[8*(i-1) +: 8] = frame_buf[i];
            for (int ch = 0; ch < NUM_ANALOG; ch++)
                chan_val[ch] = payload[RAW_W*ch +: RAW_W];
            chan_val[16] = frame_buf[23][DIG0_BIT] ? RAW_FULL : '0;
            chan_val[17] = frame_buf[23][DIG1_BIT] ? RAW_FULL : '0;
            failsafe_q   = frame_buf[23][FAILSAFE_BIT];
            if (frame_buf[23][LOST_BIT])
                lost_q++;
        end
        else
        begin
            bad_q++;
        end

        for (int k = 0; k < OUT_CHANNELS && k < NUM_CH; k++)
        begin
            is_arm  = (cfg_reg[CFG_ARM_IDX][CH_IDX_W-1:0] == CH_IDX_W'(k));
            is_mode = (cfg_reg[CFG_MODE_IDX][CH_IDX_W-1:0] == CH_IDX_W'(k));
            is_uni  = is_arm || is_mode ||
                      (cfg_reg[CFG_THROTTLE_IDX][CH_IDX_W-1:0] == CH_IDX_W'(k));
            v = scale_channel(chan_val[k], is_uni ? $signed(cfg_reg[CFG_DEST_LOW_U])
                                                  : $signed(cfg_reg[CFG_DEST_LOW_S]));
            // arm switch first, then the mode switch on its result
            if (is_arm)
                v = (v < Q_HALF) ? Q_ZERO : Q_ONE;
            if (is_mode)
                v = (v < Q_QUARTER) ? Q_ZERO : (v < Q_3QUART) ? Q_ONE : Q_TWO;
            r.idx      = CH_IDX_W'(k);
            r.raw      = chan_val[k];
            r.value    = v;
            r.good     = good;
            r.failsafe = failsafe_q;
            r.lost     = lost_q;
            r.bad      = bad_q;
            r.last     = (k == OUT_CHANNELS - 1);
            expected_channels.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic compare_result();
        chan_result_t e;
        if (expected_channels.size() == 0)
        begin
            $error("result item with nothing expected: channel_index %0d", channel_index);
            errors++;
            return;
        end
        e = expected_channels.pop_front();
        check_field("channel_index", e.idx, channel_index);
        check_field("raw_value", e.raw, raw_value);
        check_field("channel_out", $signed(e.value), channel_out);
        check_field("frame_valid", e.good, frame_valid);
        check_field("failsafe_flag", e.failsafe, failsafe_flag);
        check_field("lost_count", e.lost, lost_count);
        check_field("error_count", e.bad, error_count);
        check_field("last_result", e.last, last_result);
    endtask

    // Track configuration, accepted bytes and accepted results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[CFG_SRC_MIN]      = 16'd200;
            cfg_reg[CFG_SRC_MAX]      = 16'd1800;
            cfg_reg[CFG_DEST_LOW_S]   = 16'hE000;
            cfg_reg[CFG_DEST_HIGH]    = 16'd8183;
            cfg_reg[CFG_DEST_LOW_U]   = 16'd0;
            cfg_reg[CFG_THROTTLE_IDX] = 16'd0;
            cfg_reg[CFG_ARM_IDX]      = 16'd4;
            cfg_reg[CFG_MODE_IDX]     = 16'd5;
            for (int i = 0; i < FRAME_BYTES; i++)
                frame_buf[i] = '0;
            for (int i = 0; i < NUM_CH; i++)
                chan_val[i] = '0;
            byte_pos   = 0;
            failsafe_q = 1'b0;
            lost_q     = '0;
            bad_q      = '0;
            expected_channels.delete();
        end
        else
        begin
            if (cfg_write)
                cfg_reg[cfg_index] = cfg_data & cfg_mask(cfg_idx_t'(cfg_index));
            if (in_valid && in_ready)
                predict_byte(frame_byte, frame_start);
            if (out_valid && out_ready)
                compare_result();
        end
        pending = expected_channels.size();
    end

endmodule

// ===== dv/tb_sbus_frame_decoder_scaler.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_sbus_frame_decoder_scaler
// Drives serial frame bytes and configuration into the frame decoder under
// random source and sink idling, and reports the verdict of the checker.
// ============================================================================
module tb_sbus_frame_decoder_scaler;
    import sbfd_pkg::*;

    localparam int     OUT_CH        = 6;
    localparam int     HOLD_CYCLES   = 500;
    localparam int     SETTLE_CYCLES = 64;
    localparam int     DRAIN_CYCLES  = 300;
    localparam longint CYCLE_LIMIT   = 400000;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [BYTE_W-1:0]        frame_byte;
    logic                     frame_start;
    logic                     out_valid;
    logic                     out_ready;
    logic [CH_IDX_W-1:0]      channel_index;
    logic [RAW_W-1:0]         raw_value;
    logic signed [VAL_W-1:0]  channel_out;
    logic                     frame_valid;
    logic                     failsafe_flag;
    logic [31:0]              lost_count;
    logic [31:0]              error_count;
    logic                     last_result;
    logic                     cfg_write;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    int                       errors;
    int                       pending;
    longint                   cycle_count;

    // Stimulus shaping
    int                       in_idle_pct;
    int                       out_idle_pct;
    int                       hold_req;
    int                       hold_seen;
    logic [RAW_W-1:0]         cur_src_min;
    logic [RAW_W-1:0]         cur_src_max;
    logic [CFG_DATA_W-1:0]    cfg_plan [8];
    logic [RAW_W-1:0]         tx_chan [NUM_ANALOG];
    logic [BYTE_W-1:0]        tx_flags;
    logic [BYTE_W-1:0]        tx_frame [FRAME_BYTES];

    sbus_frame_decoder_scaler #(
        .OUT_CHANNELS (OUT_CH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .frame_byte    (frame_byte),
        .frame_start   (frame_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .channel_index (channel_index),
        .raw_value     (raw_value),
        .channel_out   (channel_out),
        .frame_valid   (frame_valid),
        .failsafe_flag (failsafe_flag),
        .lost_count    (lost_count),
        .error_count   (error_count),
        .last_result   (last_result),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    channel_result_checker #(
        .OUT_CHANNELS (OUT_CH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .frame_byte    (frame_byte),
        .frame_start   (frame_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .channel_index (channel_index),
        .raw_value     (raw_value),
        .channel_out   (channel_out),
        .frame_valid   (frame_valid),
        .failsafe_flag (failsafe_flag),
        .lost_count    (lost_count),
        .error_count   (error_count),
        .last_result   (last_result),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Bound the run
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result sink: random idling, plus a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        hold_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    // Offer one byte, holding it until accepted; starts and ends at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic mark);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        frame_byte  <= b;
        frame_start <= mark;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame(input int n_bytes, input logic mark_first);
        for (int i = 0; i < n_bytes; i++)
            send_byte(tx_frame[i], (i == 0) ? mark_first : 1'b0);
    endtask

    // Build a well-formed frame from tx_chan and tx_flags
    task automatic pack_frame();
        logic [NUM_ANALOG*RAW_W-1:0] payload;
        for (int ch = 0; ch < NUM_ANALOG; ch++)
            payload[RAW_W*ch +: RAW_W] = tx_chan[ch];
        tx_frame[0] = HEADER_BYTE;
        for (int i = 1; i <= 22; i++)
            tx_frame[i] = payload[8*(i-1) +: 8];
        tx_frame[23] = tx_flags;
        tx_frame[FRAME_BYTES-1] = FOOTER_BYTE;
    endtask

    // Random channels, weighted toward the clip points and the full-scale ends
    task automatic rand_channels();
        int t;
        for (int ch = 0; ch < NUM_ANALOG; ch++)
        begin
            case ($urandom_range(0, 9))
                0:       t = 0;
                1:       t = 2047;
                2, 3:    t = int'(cur_src_min) + int'($urandom_range(0, 8)) - 4;
                4, 5:    t = int'(cur_src_max) + int'($urandom_range(0, 8)) - 4;
                default: t = $urandom_range(0, 2047);
            endcase
            if (t < 0)
                t = 0;
            if (t > 2047)
                t = 2047;
            tx_chan[ch] = RAW_W'(t);
        end
        tx_flags = BYTE_W'($urandom_range(0, 255));
    endtask

    task automatic apply_cfg();
        cfg_idx_t idx;
        idx = idx.first();
        repeat (idx.num())
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= cfg_plan[idx];
            @(negedge clk);
            idx = idx.next();
        end
        cfg_write   <= 1'b0;
        cur_src_min = cfg_plan[CFG_SRC_MIN][RAW_W-1:0];
        cur_src_max = cfg_plan[CFG_SRC_MAX][RAW_W-1:0];
    endtask

    // Drop valid and let the decoder drain before touching its registers
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        frame_byte   = '0;
        frame_start  = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_SRC_MIN;
        cfg_data     = '0;
        in_idle_pct  = 10;
        out_idle_pct = 10;
        hold_req     = 0;
        cur_src_min  = 11'd200;
        cur_src_max  = 11'd1800;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: a lost frame with failsafe, then a bad header byte
        // offered while the sink holds off, so the input stalls behind it
        hold_req++;
        rand_channels();
        tx_flags = 8'h0C;
        pack_frame();
        send_frame(FRAME_BYTES, 1'b1);
        rand_channels();
        pack_frame();
        tx_frame[0] = ~HEADER_BYTE;
        send_frame(FRAME_BYTES, 1'b0);
        settle();

        // Widest range, extreme outputs, arm and mode on one channel,
        // throttle beyond the emitted channels
        cfg_plan[CFG_SRC_MIN]      = 16'h0000;
        cfg_plan[CFG_SRC_MAX]      = 16'h07FF;
        cfg_plan[CFG_DEST_LOW_S]   = 16'h8000;
        cfg_plan[CFG_DEST_HIGH]    = 16'h7FFF;
        cfg_plan[CFG_DEST_LOW_U]   = 16'h8000;
        cfg_plan[CFG_THROTTLE_IDX] = 16'd17;
        cfg_plan[CFG_ARM_IDX]      = 16'd0;
        cfg_plan[CFG_MODE_IDX]     = 16'd0;
        apply_cfg();
        for (int ch = 0; ch < NUM_ANALOG; ch++)
            tx_chan[ch] = (ch % 4 == 0) ? 11'd0 : (ch % 4 == 1) ? RAW_FULL :
                          (ch % 4 == 2) ? 11'd1 : 11'd2046;
        tx_flags = 8'h0B;
        pack_frame();
        send_frame(FRAME_BYTES, 1'b1);
        settle();

        // Inverted range with reversed output extremes, junk in the upper
        // data bits, and a stretch with no idling on either side: a frame
        // cut short by a new start marker, then a full one
        cfg_plan[CFG_SRC_MIN]      = 16'hFFFF;
        cfg_plan[CFG_SRC_MAX]      = 16'h0000;
        cfg_plan[CFG_DEST_LOW_S]   = 16'h7FFF;
        cfg_plan[CFG_DEST_HIGH]    = 16'h8000;
        cfg_plan[CFG_DEST_LOW_U]   = 16'h7FFF;
        cfg_plan[CFG_THROTTLE_IDX] = 16'hFFE0;
        cfg_plan[CFG_ARM_IDX]      = 16'd17;
        cfg_plan[CFG_MODE_IDX]     = 16'd1;
        apply_cfg();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        rand_channels();
        pack_frame();
        send_frame(5, 1'b1);
        rand_channels();
        pack_frame();
        send_frame(FRAME_BYTES, 1'b1);
        settle();
        in_idle_pct  = 10;
        out_idle_pct = 10;

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
